// File: design/rwsel_pkg.sv
package rwsel_pkg;

    localparam int FIT_W   = 17;
    localparam int SLOT_W  = 6;
    localparam int RAND_W  = 31;
    localparam int CNT_W   = 7;
    localparam int IDX_W   = 6;
    // total of at most 127 entries of 17 bits
    localparam int SUM_W   = FIT_W + CNT_W;
    localparam int SCALE_W = 10;
    localparam int PROD_W  = RAND_W + SCALE_W;
    localparam int DCNT_W  = 6;

    localparam logic [SCALE_W-1:0] SCALE_MILLI = 10'd1000;
    localparam logic [CNT_W-1:0]   COUNT_RESET = 7'd10;
    localparam logic [DCNT_W-1:0]  DIV_STEPS   = 6'(PROD_W);

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SELECT = 1'b1;

    localparam logic ST_OK   = 1'b0;
    localparam logic ST_ZERO = 1'b1;

    typedef struct packed {
        logic              op;
        logic [SLOT_W-1:0] slot;
        logic [FIT_W-1:0]  fitness_milli;
        logic [RAND_W-1:0] random_word;
    } t_req;

    typedef struct packed {
        logic [IDX_W-1:0] chosen_index;
        logic             status;
    } t_result;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SUM,
        S_DIV,
        S_WALK,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic launch;
        logic sum_run;
        logic div_init;
        logic div_run;
        logic walk_init;
        logic walk_run;
    } t_cmd;

    typedef struct packed {
        logic sum_done;
        logic total_zero;
        logic div_done;
        logic walk_done;
    } t_sts;

endpackage

// File: design/rwsel_ram.sv
module rwsel_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// File: design/rwsel_ctrl.sv
module rwsel_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic          i_op,
    input  rwsel_pkg::t_sts i_sts,
    output rwsel_pkg::t_cmd o_cmd,
    output logic          o_busy,
    output logic          o_strobe
);
    import rwsel_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start && i_op == OP_SELECT) begin
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                if (i_sts.sum_done) begin
                    n_state = i_sts.total_zero ? S_DONE : S_DIV;
                end
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (i_sts.walk_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd    = '0;
        o_busy   = 1'b1;
        o_strobe = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_busy        = 1'b0;
                o_cmd.load    = i_start && i_op == OP_LOAD;
                o_cmd.launch  = i_start && i_op == OP_SELECT;
            end
            S_SUM: begin
                o_cmd.sum_run  = 1'b1;
                o_cmd.div_init = i_sts.sum_done && !i_sts.total_zero;
            end
            S_DIV: begin
                o_cmd.div_run   = !i_sts.div_done;
                o_cmd.walk_init = i_sts.div_done;
            end
            S_WALK: begin
                o_cmd.walk_run = 1'b1;
            end
            S_DONE: begin
                o_strobe = 1'b1;
            end
            default: begin
                o_busy = 1'b1;
            end
        endcase
    end
endmodule

// File: design/rwsel_dp.sv
module rwsel_dp #(
    parameter int POP_MAX = 64
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  rwsel_pkg::t_req           i_req,
    input  rwsel_pkg::t_cmd           i_cmd,
    input  logic                      i_cfg_we,
    input  logic [rwsel_pkg::CNT_W-1:0] i_cfg_data,
    output rwsel_pkg::t_sts           o_sts,
    output rwsel_pkg::t_result        o_result
);
    import rwsel_pkg::*;

    localparam int AW = (POP_MAX > 1) ? $clog2(POP_MAX) : 1;
    localparam int XW = (AW > CNT_W) ? AW : CNT_W;

    logic [CNT_W-1:0]  r_pop_count;
    logic [CNT_W-1:0]  eff_count;
    logic [CNT_W-1:0]  r_n;
    logic [CNT_W-1:0]  r_iss;
    logic [CNT_W-1:0]  r_didx;
    logic              r_dv;
    logic              r_found;
    logic [SUM_W-1:0]  r_total;
    logic [SUM_W-1:0]  r_run;
    logic [SUM_W-1:0]  run_next;
    logic [PROD_W-1:0] r_dvd;
    logic [SUM_W-1:0]  r_rem;
    logic [SUM_W:0]    rem_sh;
    logic [DCNT_W-1:0] r_dcnt;
    logic [IDX_W-1:0]  r_pick;
    logic              issue;
    logic              slot_ok;
    logic [XW-1:0]     slot_x;
    logic [XW-1:0]     iss_x;
    logic [FIT_W-1:0]  rd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pop_count <= COUNT_RESET;
        end else if (i_cfg_we) begin
            r_pop_count <= i_cfg_data;
        end
    end

    assign eff_count = (32'(r_pop_count) > POP_MAX) ? CNT_W'(POP_MAX) : r_pop_count;
    assign slot_ok   = 32'(i_req.slot) < POP_MAX;
    assign slot_x    = XW'(i_req.slot);
    assign iss_x     = XW'(r_iss);
    assign issue     = (i_cmd.sum_run || (i_cmd.walk_run && !r_found)) && (r_iss < r_n);

    rwsel_ram #(
        .WIDTH (FIT_W),
        .DEPTH (POP_MAX)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load && slot_ok),
        .i_waddr (slot_x[AW-1:0]),
        .i_wdata (i_req.fitness_milli),
        .i_re    (issue),
        .i_raddr (iss_x[AW-1:0]),
        .o_rdata (rd_data)
    );

    assign run_next = r_run + SUM_W'(rd_data);
    assign rem_sh   = {r_rem, r_dvd[PROD_W-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iss   <= '0;
            r_dv    <= 1'b0;
            r_found <= 1'b0;
            r_dcnt  <= '0;
        end else begin
            r_dv <= issue;
            if (issue) begin
                r_iss <= r_iss + 1'b1;
            end
            if (i_cmd.launch || i_cmd.walk_init) begin
                r_iss   <= '0;
                r_found <= 1'b0;
            end else if (i_cmd.walk_run && r_dv && !r_found && run_next > r_rem) begin
                r_found <= 1'b1;
            end
            if (i_cmd.div_init) begin
                r_dcnt <= DIV_STEPS;
            end else if (i_cmd.div_run) begin
                r_dcnt <= r_dcnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_didx <= r_iss;
        end
        if (i_cmd.launch) begin
            r_n     <= eff_count;
            r_total <= '0;
            r_pick  <= '0;
            r_dvd   <= PROD_W'(i_req.random_word) * PROD_W'(SCALE_MILLI);
        end else if (i_cmd.sum_run && r_dv) begin
            r_total <= r_total + SUM_W'(rd_data);
        end
        if (i_cmd.div_init) begin
            r_rem <= '0;
        end else if (i_cmd.div_run) begin
            // restoring step: one quotient bit per cycle
            if (rem_sh >= {1'b0, r_total}) begin
                r_rem <= SUM_W'(rem_sh - {1'b0, r_total});
            end else begin
                r_rem <= rem_sh[SUM_W-1:0];
            end
            r_dvd <= {r_dvd[PROD_W-2:0], 1'b0};
        end
        if (i_cmd.walk_init) begin
            r_run <= '0;
        end else if (i_cmd.walk_run && r_dv && !r_found) begin
            r_run <= run_next;
            if (run_next > r_rem) begin
                r_pick <= r_didx[IDX_W-1:0];
            end
        end
    end

    always_comb begin
        o_sts.sum_done   = (r_iss == r_n) && !r_dv;
        o_sts.total_zero = r_total == '0;
        o_sts.div_done   = r_dcnt == '0;
        o_sts.walk_done  = r_found || ((r_iss == r_n) && !r_dv);
    end

    assign o_result.chosen_index = r_pick;
    assign o_result.status       = (r_total == '0) ? ST_ZERO : ST_OK;
endmodule

// File: design/roulette_wheel_selector.sv
// Fitness-proportionate selector. A load (op 0) writes one table entry
// and leaves busy low; start may be raised again in the next cycle. A
// select (op 1) keeps busy high over the sum, one table read per cycle
// over the n entries of the effective population count, a bit-serial
// restoring modulo, then one read per cycle for the cumulative walk,
// which stops at the chosen entry. o_strobe is high for exactly one cycle
// with the result on o_result and cannot be stalled; capture it then. A
// zero total skips the modulo and walk and returns status 1 with index 0.
// The config write is always ready and is to be used only while busy is low.
module roulette_wheel_selector #(
    parameter int POP_MAX = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  rwsel_pkg::t_req               i_req,
    output logic                          o_strobe,
    output rwsel_pkg::t_result            o_result,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [rwsel_pkg::CNT_W-1:0]   i_cfg_data
);
    import rwsel_pkg::*;

    t_cmd cmd;
    t_sts sts;
    logic ctrl_busy;

    assign busy        = ctrl_busy;
    assign o_cfg_ready = 1'b1;

    rwsel_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_op     (i_req.op),
        .i_sts    (sts),
        .o_cmd    (cmd),
        .o_busy   (ctrl_busy),
        .o_strobe (o_strobe)
    );

    rwsel_dp #(
        .POP_MAX (POP_MAX)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (i_req),
        .i_cmd      (cmd),
        .i_cfg_we   (i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .o_sts      (sts),
        .o_result   (o_result)
    );
endmodule

// File: tb/roulette_wheel_selector_tb.sv
`timescale 1ns / 100ps

module roulette_wheel_selector_tb;

    import rwsel_pkg::*;

    localparam int POP_MAX = 64;
    localparam int N_PHASES = 8;
    localparam int PHASE_ITEMS = 133;

    typedef enum logic [1:0] {
        STEP_LOAD,
        STEP_SELECT,
        STEP_COUNT
    } t_step_kind;

    typedef struct {
        t_step_kind       kind;
        t_req             req;
        logic [CNT_W-1:0] count;
        bit               typed;
        t_result          want;
    } t_plan_step;

    logic             i_clk;
    logic             i_rst_n;
    logic             start;
    logic             busy;
    t_req             i_req;
    logic             o_strobe;
    t_result          o_result;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic [CNT_W-1:0] i_cfg_data;

    logic [FIT_W-1:0] fit_tbl [POP_MAX];
    logic [CNT_W-1:0] pop_count;
    t_result          pending_picks [$];
    t_plan_step       plan [$];

    int unsigned mismatches;
    int unsigned n_loads;
    int unsigned n_selects;
    int unsigned n_zero_totals;
    int unsigned n_count_writes;

    roulette_wheel_selector #(
        .POP_MAX(POP_MAX)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_req(i_req),
        .o_strobe(o_strobe),
        .o_result(o_result),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data(i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    task automatic report_mismatch(input string what);
        $display("ERROR at %0t ns: %s", $time, what);
        mismatches++;
    endtask

    function automatic t_result predict_pick(input logic [RAND_W-1:0] rnd);
        t_result         res;
        int unsigned     n;
        longint unsigned total;
        longint unsigned draw;
        longint unsigned running;
        bit              found;
        n = (pop_count > POP_MAX) ? POP_MAX : pop_count;
        total = 0;
        for (int i = 0; i < n; i++) begin
            total += fit_tbl[i];
        end
        res.chosen_index = '0;
        res.status = ST_ZERO;
        if (total != 0) begin
            res.status = ST_OK;
            draw = (64'(rnd) * 64'(SCALE_MILLI)) % total;
            running = 0;
            found = 1'b0;
            for (int i = 0; i < n; i++) begin
                running += fit_tbl[i];
                if (!found && running > draw) begin
                    res.chosen_index = IDX_W'(i);
                    found = 1'b1;
                end
            end
        end
        return res;
    endfunction

    function automatic void plan_load(input int slot, input int fit);
        t_plan_step s;
        s.kind = STEP_LOAD;
        s.req = '0;
        s.req.op = OP_LOAD;
        s.req.slot = SLOT_W'(slot);
        s.req.fitness_milli = FIT_W'(fit);
        s.count = '0;
        s.typed = 1'b0;
        s.want = '0;
        plan.push_back(s);
    endfunction

    function automatic void plan_select(input logic [RAND_W-1:0] rnd, input bit typed,
                                        input int idx, input logic st);
        t_plan_step s;
        s.kind = STEP_SELECT;
        s.req = '0;
        s.req.op = OP_SELECT;
        s.req.random_word = rnd;
        s.count = '0;
        s.typed = typed;
        s.want.chosen_index = IDX_W'(idx);
        s.want.status = st;
        plan.push_back(s);
    endfunction

    function automatic void plan_count(input int cnt);
        t_plan_step s;
        s.kind = STEP_COUNT;
        s.req = '0;
        s.count = CNT_W'(cnt);
        s.typed = 1'b0;
        s.want = '0;
        plan.push_back(s);
    endfunction

    // request stays presented until busy is seen low at an edge
    task automatic issue(input t_req r, input bit typed, input t_result want);
        t_result pick;
        start <= 1'b1;
        i_req <= r;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        if (r.op == OP_LOAD) begin
            fit_tbl[r.slot] = r.fitness_milli;
            n_loads++;
        end else begin
            pick = typed ? want : predict_pick(r.random_word);
            if (pick.status == ST_ZERO) n_zero_totals++;
            pending_picks.push_back(pick);
            n_selects++;
        end
    endtask

    task automatic set_population(input logic [CNT_W-1:0] cnt);
        start <= 1'b0;
        while (pending_picks.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        while (busy) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= cnt;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        pop_count = cnt;
        n_count_writes++;
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_strobe) begin
            if (pending_picks.size() == 0) begin
                report_mismatch($sformatf("result with none pending: index %0d status %0d",
                                          o_result.chosen_index, o_result.status));
            end else begin
                want = pending_picks.pop_front();
                if (o_result.chosen_index !== want.chosen_index)
                    report_mismatch($sformatf("chosen_index got %0d, want %0d",
                                              o_result.chosen_index, want.chosen_index));
                if (o_result.status !== want.status)
                    report_mismatch($sformatf("status got %0d, want %0d",
                                              o_result.status, want.status));
            end
        end
    end

    initial begin
        #30_000_000;
        $display("Mismatches found");
        $finish;
    end

    initial begin
        t_req        r;
        int unsigned idle_pct;
        int unsigned gap;
        int unsigned cnt;
        int unsigned phase_counts [N_PHASES];

        phase_counts = '{64, 1, 127, 7, 0, 2, 40, 0};
        mismatches = 0;
        n_loads = 0;
        n_selects = 0;
        n_zero_totals = 0;
        n_count_writes = 0;
        pop_count = COUNT_RESET;
        for (int i = 0; i < POP_MAX; i++) fit_tbl[i] = '0;

        i_rst_n = 1'b0;
        start = 1'b0;
        i_req = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // every entry written once so no selection reads an unloaded one
        for (int s = 0; s < POP_MAX; s++) begin
            r = '0;
            r.op = OP_LOAD;
            r.slot = SLOT_W'(s);
            r.random_word = RAND_W'($urandom);
            issue(r, 1'b0, '0);
        end

        // reset count of 10 keeps entry 10 out of the total
        plan_load(10, 5000);
        plan_select(31'd12345, 1'b1, 0, ST_ZERO);
        plan_load(9, 1);
        plan_select(31'h7FFF_FFFF, 1'b1, 9, ST_OK);
        plan_load(0, 131071);
        plan_select(31'd0, 1'b1, 0, ST_OK);
        plan_select(31'h7FFF_FFFF, 1'b0, 0, ST_OK);
        plan_count(0);
        plan_select(31'd777, 1'b1, 0, ST_ZERO);
        plan_count(127);
        plan_load(63, 100000);
        plan_select(31'd0, 1'b1, 0, ST_OK);
        plan_load(0, 0);
        plan_load(9, 0);
        plan_load(10, 0);
        plan_select(31'h7FFF_FFFF, 1'b1, 63, ST_OK);
        plan_count(64);
        plan_select(31'd5, 1'b1, 63, ST_OK);
        plan_count(1);
        plan_select(31'd42, 1'b1, 0, ST_ZERO);
        plan_load(0, 100000);
        plan_select(31'h7FFF_FFFF, 1'b1, 0, ST_OK);
        plan_load(1, 65535);
        plan_count(2);
        plan_select(31'd1, 1'b0, 0, ST_OK);

        foreach (plan[k]) begin
            if (plan[k].kind == STEP_COUNT)
                set_population(plan[k].count);
            else
                issue(plan[k].req, plan[k].typed, plan[k].want);
        end

        for (int p = 0; p < N_PHASES; p++) begin
            cnt = (p == N_PHASES - 1) ? $urandom_range(127, 1) : phase_counts[p];
            set_population(CNT_W'(cnt));
            case (p % 4)
                1: begin
                    idle_pct = 66;
                end
                3: begin
                    idle_pct = 16;
                end
                default: begin
                    idle_pct = 0;
                end
            endcase
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                r.slot = SLOT_W'($urandom);
                r.random_word = RAND_W'($urandom);
                if ($urandom_range(5) == 0)
                    r.fitness_milli = '0;
                else if ($urandom_range(7) == 0)
                    r.fitness_milli = FIT_W'($urandom);
                else
                    r.fitness_milli = FIT_W'($urandom_range(100000));
                r.op = ($urandom_range(99) < 40) ? OP_LOAD : OP_SELECT;
                issue(r, 1'b0, '0);
                if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
                    gap = ($urandom_range(3) != 0) ? $urandom_range(4, 1)
                                                   : $urandom_range(180, 5);
                    start <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end

        start <= 1'b0;
        while (pending_picks.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (pending_picks.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_picks.size()));

        $display("Run covered %0d loads and %0d selections, %0d of them with a zero total,",
                 n_loads, n_selects, n_zero_totals);
        $display("over %0d population count writes from 0 to 127, with and without idling.",
                 n_count_writes);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
